/* design/jsdu_pkg.sv */
// ----------------------------------------------------------------------------
// jsdu_pkg: shared types for the JSON string to UTF-16 decoder
// Result kinds, decoder phases and the per-byte result bundle that travels
// from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package jsdu_pkg;

	// Default depth of the bundle queue between front and back end
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		KIND_UNIT      = 4'd0,
		KIND_DONE      = 4'd1,
		ERR_NO_QUOTE   = 4'd2,
		ERR_TRUNC_ESC  = 4'd3,
		ERR_BAD_HEX    = 4'd4,
		ERR_BAD_LO_HEX = 4'd5,
		ERR_LONE_HIGH  = 4'd6,
		ERR_LONE_LOW   = 4'd7,
		ERR_UNK_ESC    = 4'd8,
		ERR_BAD_UTF8   = 4'd9,
		ERR_UNTERM     = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		PH_WAIT     = 3'd0,
		PH_BODY     = 3'd1,
		PH_ESC      = 3'd2,
		PH_HEX_HI   = 3'd3,
		PH_UTF8     = 3'd4,
		PH_PAIR_BSL = 3'd5,
		PH_PAIR_U   = 3'd6,
		PH_HEX_LO   = 3'd7
	} phase_t;

	// All results of one input byte: up to two code units, then an optional
	// terminating result (done, unterminated or an error).
	typedef struct packed {
		logic [1:0]  unit_cnt;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        term_en;
		kind_t       term_kind;
	} bundle_t;

endpackage

/* design/jsdu_front.sv */
// ----------------------------------------------------------------------------
// jsdu_front: byte classifier and decoder state machine
// Takes one byte per cycle unless the queue is full, updates the
// string/escape/UTF-8 state and produces the bundle of results of that byte.
// ----------------------------------------------------------------------------
module jsdu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              push,
	output jsdu_pkg::bundle_t push_bundle
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// {valid, value} of one hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	jsdu_pkg::phase_t phase_q, phase_n;
	logic [20:0] cp_acc_q, cp_acc_n;
	logic [1:0]  rem_q, rem_n;
	logic [1:0]  seq_len_q, seq_len_n;
	logic [15:0] hex_acc_q, hex_acc_n;
	logic [1:0]  hex_cnt_q, hex_cnt_n;
	logic [9:0]  hi_bits_q, hi_bits_n;
	logic        disc_q, disc_n;

	logic              fire;
	logic              fail_en;
	jsdu_pkg::kind_t   fail_kind;
	logic              char_done;
	jsdu_pkg::bundle_t bnd;

	logic [4:0]  hd;
	logic [15:0] hex_v;
	logic [20:0] cp_new;
	logic [19:0] cp_off;
	logic        cp_bad;
	logic [1:0]  rem_dec;
	logic        low_half;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;

	assign hd       = hex_digit(data_byte);
	assign hex_v    = {hex_acc_q[11:0], hd[3:0]};
	assign cp_new   = {cp_acc_q[14:0], data_byte[5:0]};
	assign cp_off   = 20'(cp_new - 21'h10000);
	assign rem_dec  = rem_q - 2'd1;
	assign low_half = (phase_q == jsdu_pkg::PH_HEX_LO);
	assign cp_bad   = (seq_len_q == 2'd1 && cp_new < 21'h80) ||
	                  (seq_len_q == 2'd2 && cp_new < 21'h800) ||
	                  (seq_len_q == 2'd3 && cp_new < 21'h10000) ||
	                  (cp_new > 21'h10FFFF) ||
	                  (cp_new >= 21'hD800 && cp_new <= 21'hDFFF);

	always_comb begin
		phase_n   = phase_q;
		cp_acc_n  = cp_acc_q;
		rem_n     = rem_q;
		seq_len_n = seq_len_q;
		hex_acc_n = hex_acc_q;
		hex_cnt_n = hex_cnt_q;
		hi_bits_n = hi_bits_q;
		disc_n    = disc_q;
		fail_en   = 1'b0;
		fail_kind = jsdu_pkg::KIND_UNIT;
		char_done = 1'b0;
		bnd.unit_cnt  = 2'd0;
		bnd.unit0     = 16'd0;
		bnd.unit1     = 16'd0;
		bnd.term_en   = 1'b0;
		bnd.term_kind = jsdu_pkg::KIND_UNIT;

		if (disc_q) begin
			if (last_byte) begin
				disc_n  = 1'b0;
				phase_n = jsdu_pkg::PH_WAIT;
			end
		end else begin
			unique case (phase_q) inside
				jsdu_pkg::PH_BODY: begin
					if (data_byte == CH_QUOTE) begin
						bnd.term_en   = 1'b1;
						bnd.term_kind = jsdu_pkg::KIND_DONE;
						phase_n       = jsdu_pkg::PH_WAIT;
					end else if (data_byte == CH_BSL) begin
						phase_n   = jsdu_pkg::PH_ESC;
						fail_en   = last_byte;
						fail_kind = jsdu_pkg::ERR_TRUNC_ESC;
					end else if (!data_byte[7]) begin
						bnd.unit_cnt = 2'd1;
						bnd.unit0    = {8'd0, data_byte};
						char_done    = 1'b1;
					end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
					             data_byte[7:3] == 5'b11110) begin
						if (data_byte[7:5] == 3'b110) begin
							seq_len_n = 2'd1;
							cp_acc_n  = {16'd0, data_byte[4:0]};
						end else if (data_byte[7:4] == 4'b1110) begin
							seq_len_n = 2'd2;
							cp_acc_n  = {17'd0, data_byte[3:0]};
						end else begin
							seq_len_n = 2'd3;
							cp_acc_n  = {18'd0, data_byte[2:0]};
						end
						rem_n     = seq_len_n;
						phase_n   = jsdu_pkg::PH_UTF8;
						fail_en   = last_byte;
						fail_kind = jsdu_pkg::ERR_BAD_UTF8;
					end else begin
						fail_en   = 1'b1;
						fail_kind = jsdu_pkg::ERR_BAD_UTF8;
					end
				end
				jsdu_pkg::PH_UTF8: begin
					fail_kind = jsdu_pkg::ERR_BAD_UTF8;
					if (data_byte[7:6] != 2'b10) begin
						fail_en = 1'b1;
					end else begin
						cp_acc_n = cp_new;
						rem_n    = rem_dec;
						if (rem_dec != 2'd0) begin
							fail_en = last_byte;
						end else if (cp_bad) begin
							fail_en = 1'b1;
						end else begin
							char_done = 1'b1;
							if (cp_new[20:16] == 5'd0) begin
								bnd.unit_cnt = 2'd1;
								bnd.unit0    = cp_new[15:0];
							end else begin
								bnd.unit_cnt = 2'd2;
								bnd.unit0    = {6'b110110, cp_off[19:10]};
								bnd.unit1    = {6'b110111, cp_off[9:0]};
							end
						end
					end
				end
				jsdu_pkg::PH_ESC: begin
					bnd.unit_cnt = 2'd1;
					char_done    = 1'b1;
					unique case (data_byte)
						CH_QUOTE, CH_BSL, CH_SLASH: bnd.unit0 = {8'd0, data_byte};
						CH_B: bnd.unit0 = 16'h0008;
						CH_F: bnd.unit0 = 16'h000C;
						CH_N: bnd.unit0 = 16'h000A;
						CH_R: bnd.unit0 = 16'h000D;
						CH_T: bnd.unit0 = 16'h0009;
						CH_U: begin
							bnd.unit_cnt = 2'd0;
							char_done    = 1'b0;
							hex_acc_n    = 16'd0;
							hex_cnt_n    = 2'd0;
							phase_n      = jsdu_pkg::PH_HEX_HI;
							fail_en      = last_byte;
							fail_kind    = jsdu_pkg::ERR_BAD_HEX;
						end
						default: begin
							bnd.unit_cnt = 2'd0;
							char_done    = 1'b0;
							fail_en      = 1'b1;
							fail_kind    = jsdu_pkg::ERR_UNK_ESC;
						end
					endcase
				end
				jsdu_pkg::PH_HEX_HI, jsdu_pkg::PH_HEX_LO: begin
					fail_kind = low_half ? jsdu_pkg::ERR_BAD_LO_HEX : jsdu_pkg::ERR_BAD_HEX;
					if (!hd[4]) begin
						fail_en = 1'b1;
					end else begin
						hex_acc_n = hex_v;
						if (hex_cnt_q != 2'd3) begin
							hex_cnt_n = hex_cnt_q + 2'd1;
							fail_en   = last_byte;
						end else begin
							hex_cnt_n = 2'd0;
							if (low_half) begin
								if (hex_v[15:10] == 6'b110111) begin
									// surrogate pair complete
									bnd.unit_cnt = 2'd2;
									bnd.unit0    = {6'b110110, hi_bits_q};
									bnd.unit1    = hex_v;
									char_done    = 1'b1;
								end else begin
									fail_en   = 1'b1;
									fail_kind = jsdu_pkg::ERR_LONE_HIGH;
								end
							end else if (hex_v[15:10] == 6'b110110) begin
								hi_bits_n = hex_v[9:0];
								phase_n   = jsdu_pkg::PH_PAIR_BSL;
								fail_en   = last_byte;
								fail_kind = jsdu_pkg::ERR_LONE_HIGH;
							end else if (hex_v[15:10] == 6'b110111) begin
								fail_en   = 1'b1;
								fail_kind = jsdu_pkg::ERR_LONE_LOW;
							end else begin
								bnd.unit_cnt = 2'd1;
								bnd.unit0    = hex_v;
								char_done    = 1'b1;
							end
						end
					end
				end
				jsdu_pkg::PH_PAIR_BSL: begin
					fail_kind = jsdu_pkg::ERR_LONE_HIGH;
					if (data_byte != CH_BSL) begin
						fail_en = 1'b1;
					end else begin
						phase_n = jsdu_pkg::PH_PAIR_U;
						fail_en = last_byte;
					end
				end
				jsdu_pkg::PH_PAIR_U: begin
					if (data_byte != CH_U) begin
						fail_en   = 1'b1;
						fail_kind = jsdu_pkg::ERR_LONE_HIGH;
					end else begin
						hex_acc_n = 16'd0;
						hex_cnt_n = 2'd0;
						phase_n   = jsdu_pkg::PH_HEX_LO;
						fail_en   = last_byte;
						fail_kind = jsdu_pkg::ERR_BAD_LO_HEX;
					end
				end
				default: begin
					// waiting for the opening quote
					if (data_byte != CH_QUOTE) begin
						fail_en   = 1'b1;
						fail_kind = jsdu_pkg::ERR_NO_QUOTE;
					end else if (last_byte) begin
						bnd.term_en   = 1'b1;
						bnd.term_kind = jsdu_pkg::ERR_UNTERM;
						phase_n       = jsdu_pkg::PH_WAIT;
					end else begin
						phase_n = jsdu_pkg::PH_BODY;
					end
				end
			endcase

			if (char_done) begin
				phase_n = jsdu_pkg::PH_BODY;
				if (last_byte) begin
					bnd.term_en   = 1'b1;
					bnd.term_kind = jsdu_pkg::ERR_UNTERM;
					phase_n       = jsdu_pkg::PH_WAIT;
				end
			end
			if (fail_en) begin
				bnd.term_en   = 1'b1;
				bnd.term_kind = fail_kind;
				phase_n       = jsdu_pkg::PH_WAIT;
				disc_n        = !last_byte;
			end
		end
	end

	assign push        = fire && (bnd.unit_cnt != 2'd0 || bnd.term_en);
	assign push_bundle = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jsdu_pkg::PH_WAIT;
			cp_acc_q  <= '0;
			rem_q     <= '0;
			seq_len_q <= '0;
			hex_acc_q <= '0;
			hex_cnt_q <= '0;
			hi_bits_q <= '0;
			disc_q    <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_n;
			cp_acc_q  <= cp_acc_n;
			rem_q     <= rem_n;
			seq_len_q <= seq_len_n;
			hex_acc_q <= hex_acc_n;
			hex_cnt_q <= hex_cnt_n;
			hi_bits_q <= hi_bits_n;
			disc_q    <= disc_n;
		end
	end

endmodule

/* design/jsdu_queue.sv */
// ----------------------------------------------------------------------------
// jsdu_queue: small bundle queue between front and back end
// Register-based FIFO, one write and one read per cycle.
// ----------------------------------------------------------------------------
module jsdu_queue #(
	parameter int DEPTH = jsdu_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsdu_pkg::bundle_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output jsdu_pkg::bundle_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsdu_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

/* design/jsdu_back.sv */
// ----------------------------------------------------------------------------
// jsdu_back: result serializer and output register
// Walks the results of the head bundle, one per transfer.
// ----------------------------------------------------------------------------
module jsdu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  jsdu_pkg::bundle_t q_head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        out_kind,
	output logic [15:0]       out_unit,
	output logic              out_last
);

	logic [1:0]      idx_q;
	logic [1:0]      total;
	logic            is_last;
	logic            load;
	logic            valid_q;
	jsdu_pkg::kind_t kind_sel;
	logic [15:0]     unit_sel;
	jsdu_pkg::kind_t kind_q;
	logic [15:0]     unit_q;
	logic            last_q;

	assign total   = q_head.unit_cnt + {1'b0, q_head.term_en};
	assign is_last = (idx_q == total - 2'd1);
	assign load    = q_valid && (!valid_q || out_ready);
	assign pop     = load && is_last;

	always_comb begin
		if (idx_q < q_head.unit_cnt) begin
			kind_sel = jsdu_pkg::KIND_UNIT;
			unit_sel = (idx_q == 2'd0) ? q_head.unit0 : q_head.unit1;
		end else begin
			kind_sel = q_head.term_kind;
			unit_sel = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_sel;
			unit_q <= unit_sel;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_unit  = unit_q;
	assign out_last  = last_q;

endmodule

/* design/json_string_decode_utf16.sv */
// ----------------------------------------------------------------------------
// json_string_decode_utf16: quoted JSON string to UTF-16 code units
// An accepted byte's results pass through the queue, then the output register.
// Throughput: one byte per cycle while each byte yields at most one result
// and m_tready is high; a byte with more results is limited by the serializer.
// Reset (arst_n low): string state returns to waiting for the opening quote,
// the queue and output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module json_string_decode_utf16 #(
	parameter int QUEUE_DEPTH = jsdu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream: one string byte per transfer
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// result stream: one result per transfer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic [3:0]  m_tuser,   // [3:0] result_kind
	output logic        m_tlast    // last_of_run
);

	// Front end to queue
	logic              push;
	jsdu_pkg::bundle_t push_bundle;
	logic              q_full;

	// Queue to back end
	logic              q_valid;
	logic              pop;
	jsdu_pkg::bundle_t q_head;

	logic [15:0]       unit;

	// Front: decodes each byte in the cycle it is accepted and writes the
	// whole set of results of that byte as one bundle. It only stalls when
	// the queue is full.
	jsdu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.data_byte   (s_tdata),
		.last_byte   (s_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_bundle (push_bundle)
	);

	// Queue decouples the decoder from downstream backpressure and from
	// bytes that expand into two or three results.
	jsdu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_bundle),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Back: one result per transfer from a registered output stage, with
	// last_of_run on the final result of each bundle.
	jsdu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_unit  (unit),
		.out_last  (m_tlast)
	);

	assign m_tdata = unit;

endmodule
